// ===== hdl/rv64_instruction_decoder_unit_assert.svh =====
`ifndef RV64_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define RV64_INSTRUCTION_DECODER_UNIT_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define RIDU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication on the core clock and reset
`define RIDU_IMPLY(lbl, ante, cons, msg) \
  `RIDU_ASSERT(lbl, clk_i, rst_ni, (ante) |-> (cons), msg)

// next-cycle implication on the core clock and reset
`define RIDU_NEXT(lbl, ante, cons, msg) \
  `RIDU_ASSERT(lbl, clk_i, rst_ni, (ante) |=> (cons), msg)

`endif

// ===== hdl/rv64idu_pkg.sv =====
`timescale 1ns / 1ps

package rv64idu_pkg;

  // major opcodes
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP = 7'h07;
  localparam logic [6:0] OPC_OP_IMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_OP_IMMW = 7'h1B;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_STOREFP = 7'h27;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_OPW     = 7'h3B;
  localparam logic [6:0] OPC_MADD    = 7'h43;
  localparam logic [6:0] OPC_MSUB    = 7'h47;
  localparam logic [6:0] OPC_NMSUB   = 7'h4B;
  localparam logic [6:0] OPC_NMADD   = 7'h4F;
  localparam logic [6:0] OPC_OP_FP   = 7'h53;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_JAL     = 7'h6F;

  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MEXT = 7'b0000001;

  // fp funct7 groups (funct7 without its precision bit)
  localparam logic [5:0] FG_ADD   = 6'h00;
  localparam logic [5:0] FG_SUB   = 6'h02;
  localparam logic [5:0] FG_MUL   = 6'h04;
  localparam logic [5:0] FG_DIV   = 6'h06;
  localparam logic [5:0] FG_SGNJ  = 6'h08;
  localparam logic [5:0] FG_MINX  = 6'h0A;
  localparam logic [5:0] FG_SQRT  = 6'h16;
  localparam logic [5:0] FG_CMP   = 6'h28;
  localparam logic [5:0] FG_CVTFI = 6'h30;
  localparam logic [5:0] FG_CVTIF = 6'h34;
  localparam logic [5:0] FG_MVX   = 6'h38;
  localparam logic [5:0] FG_MVF   = 6'h3C;

  // alu classes
  typedef enum logic [2:0] {
    CLS_ADDR = 3'd0,
    CLS_IMM  = 3'd1,
    CLS_REG  = 3'd2,
    CLS_FP   = 3'd3,
    CLS_FMA  = 3'd4
  } alu_class_e;

  // operation codes
  localparam logic [6:0] OP_NONE     = 7'd0;
  localparam logic [6:0] OP_ADD      = 7'd1;
  localparam logic [6:0] OP_SUB      = 7'd2;
  localparam logic [6:0] OP_SLT      = 7'd3;
  localparam logic [6:0] OP_SLTU     = 7'd4;
  localparam logic [6:0] OP_XOR      = 7'd5;
  localparam logic [6:0] OP_OR       = 7'd6;
  localparam logic [6:0] OP_AND      = 7'd7;
  localparam logic [6:0] OP_SLL      = 7'd8;
  localparam logic [6:0] OP_SRA      = 7'd9;
  localparam logic [6:0] OP_SRL      = 7'd10;
  localparam logic [6:0] OP_ADDW     = 7'd11;
  localparam logic [6:0] OP_MULW     = 7'd12;
  localparam logic [6:0] OP_SUBW     = 7'd13;
  localparam logic [6:0] OP_SLLW     = 7'd14;
  localparam logic [6:0] OP_DIVW     = 7'd15;
  localparam logic [6:0] OP_DIVUW    = 7'd16;
  localparam logic [6:0] OP_SRAW     = 7'd17;
  localparam logic [6:0] OP_SRLW     = 7'd18;
  localparam logic [6:0] OP_REMW     = 7'd19;
  localparam logic [6:0] OP_REMUW    = 7'd20;
  localparam logic [6:0] OP_MUL      = 7'd21;
  localparam logic [6:0] OP_MULH     = 7'd22;
  localparam logic [6:0] OP_MULHSU   = 7'd23;
  localparam logic [6:0] OP_MULHU    = 7'd24;
  localparam logic [6:0] OP_DIV      = 7'd25;
  localparam logic [6:0] OP_DIVU     = 7'd26;
  localparam logic [6:0] OP_REM      = 7'd27;
  localparam logic [6:0] OP_FADD_S   = 7'd28;
  localparam logic [6:0] OP_FSUB_S   = 7'd30;
  localparam logic [6:0] OP_FMUL_S   = 7'd32;
  localparam logic [6:0] OP_FDIV_S   = 7'd34;
  localparam logic [6:0] OP_FSQRT_S  = 7'd36;
  localparam logic [6:0] OP_FSGNJ_S  = 7'd38;
  localparam logic [6:0] OP_FSGNJ_D  = 7'd41;
  localparam logic [6:0] OP_FMIN_S   = 7'd44;
  localparam logic [6:0] OP_FMIN_D   = 7'd46;
  localparam logic [6:0] OP_FEQ_S    = 7'd48;
  localparam logic [6:0] OP_FEQ_D    = 7'd51;
  localparam logic [6:0] OP_FCVT_W_S = 7'd54;
  localparam logic [6:0] OP_FCVT_W_D = 7'd58;
  localparam logic [6:0] OP_FCVT_S_W = 7'd62;
  localparam logic [6:0] OP_FCVT_D_W = 7'd66;
  localparam logic [6:0] OP_FCLASS_S = 7'd70;
  localparam logic [6:0] OP_FMV_X_W  = 7'd71;
  localparam logic [6:0] OP_FMV_W_X  = 7'd74;
  localparam logic [6:0] OP_FMV_D_X  = 7'd75;
  localparam logic [6:0] OP_FMADD_S  = 7'd76;
  localparam logic [6:0] OP_REMU     = 7'd84;

  typedef struct packed {
    logic       write_register;
    logic       use_immediate;
    logic       load_to_register;
    logic       read_memory;
    logic       write_memory;
    logic       is_branch;
    alu_class_e alu_class;
    logic [6:0] alu_operation;
  } dec_result_t;

  localparam int unsigned ResultBits = $bits(dec_result_t);

  function automatic logic [6:0] rtype_op(input logic [2:0] f3, input logic [6:0] f7);
    logic m;
    logic alt;
    logic [6:0] op;
    m   = (f7 == F7_MEXT);
    alt = (f7 == F7_ALT);
    case (f3)
      3'd0:    op = m ? OP_MUL    : (alt ? OP_SUB : OP_ADD);
      3'd1:    op = m ? OP_MULH   : OP_SLL;
      3'd2:    op = m ? OP_MULHSU : OP_SLT;
      3'd3:    op = m ? OP_MULHU  : OP_SLTU;
      3'd4:    op = m ? OP_DIV    : OP_XOR;
      3'd5:    op = m ? OP_DIVU   : (alt ? OP_SRA : OP_SRL);
      3'd6:    op = m ? OP_REM    : OP_OR;
      default: op = m ? OP_REMU   : OP_AND;
    endcase
    return op;
  endfunction

  function automatic logic [6:0] wide_op(input logic [6:0] opc, input logic [2:0] f3,
                                         input logic [6:0] f7);
    logic m;
    logic [6:0] op;
    m  = (f7 == F7_MEXT);
    op = rtype_op(f3, f7);
    case (f3)
      3'd0: begin
        if (opc == OPC_OP_IMMW) op = OP_ADDW;
        else op = m ? OP_MULW : ((f7 == F7_ALT) ? OP_SUBW : OP_ADDW);
      end
      3'd1: op = OP_SLLW;
      3'd4: if (m) op = OP_DIVW;
      3'd5: op = m ? OP_DIVUW : ((f7 == F7_ALT) ? OP_SRAW : OP_SRLW);
      3'd6: if (m) op = OP_REMW;
      3'd7: if (m) op = OP_REMUW;
      default: ;
    endcase
    return op;
  endfunction

  function automatic logic [6:0] fp_op(input logic [2:0] f3, input logic [4:0] f5,
                                       input logic [6:0] f7);
    logic [6:0] dbl;
    logic [6:0] f3x;
    logic [6:0] f5x;
    logic [6:0] op;
    dbl = {6'd0, f7[0]};
    f3x = {4'd0, f3};
    f5x = {2'd0, f5};
    op  = OP_NONE;
    case (f7[6:1])
      FG_ADD:  op = OP_FADD_S + dbl;
      FG_SUB:  op = OP_FSUB_S + dbl;
      FG_MUL:  op = OP_FMUL_S + dbl;
      FG_DIV:  op = OP_FDIV_S + dbl;
      FG_SQRT: if (f5 == 5'd0) op = OP_FSQRT_S + dbl;
      FG_SGNJ: if (f3 <= 3'd2) op = (f7[0] ? OP_FSGNJ_D : OP_FSGNJ_S) + f3x;
      FG_MINX: if (f3 <= 3'd1) op = (f7[0] ? OP_FMIN_D : OP_FMIN_S) + f3x;
      // eq, lt, le in that order
      FG_CMP:  if (f3 <= 3'd2) op = (f7[0] ? OP_FEQ_D : OP_FEQ_S) + (7'd2 - f3x);
      FG_CVTFI: if (f5 <= 5'd3) op = (f7[0] ? OP_FCVT_W_D : OP_FCVT_W_S) + f5x;
      FG_CVTIF: if (f5 <= 5'd3) op = (f7[0] ? OP_FCVT_D_W : OP_FCVT_S_W) + f5x;
      FG_MVX: begin
        if (f3 == 3'd1) op = OP_FCLASS_S + {dbl[5:0], 1'b0};
        else if (f3 == 3'd0) op = OP_FMV_X_W + {dbl[5:0], 1'b0};
      end
      FG_MVF:  op = f7[0] ? OP_FMV_D_X : OP_FMV_W_X;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic dec_result_t decode(input logic [31:0] w);
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  f5;
    logic [6:0]  f7;
    dec_result_t r;
    opc = w[6:0];
    f3  = w[14:12];
    f5  = w[24:20];
    f7  = w[31:25];
    r   = '0;
    r.alu_class = CLS_ADDR;
    case (opc)
      OPC_OP:      begin r.write_register = 1'b1; r.alu_class = CLS_REG; end
      OPC_OP_IMM:  begin
        r.write_register = 1'b1; r.use_immediate = 1'b1; r.alu_class = CLS_IMM;
      end
      OPC_LOAD, OPC_LOAD_FP: begin
        r.write_register   = 1'b1;
        r.use_immediate    = 1'b1;
        r.load_to_register = 1'b1;
        r.read_memory      = 1'b1;
      end
      OPC_STORE, OPC_STOREFP: begin
        r.use_immediate = 1'b1; r.write_memory = 1'b1;
      end
      OPC_BRANCH:  begin r.is_branch = 1'b1; r.alu_class = CLS_IMM; end
      OPC_LUI, OPC_JALR: begin r.write_register = 1'b1; r.use_immediate = 1'b1; end
      OPC_AUIPC, OPC_JAL: r.write_register = 1'b1;
      OPC_OP_IMMW: begin
        r.write_register = 1'b1; r.use_immediate = 1'b1; r.alu_class = CLS_REG;
      end
      OPC_OPW:     begin r.write_register = 1'b1; r.alu_class = CLS_REG; end
      OPC_OP_FP:   begin r.write_register = 1'b1; r.alu_class = CLS_FP; end
      OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
        r.write_register = 1'b1; r.alu_class = CLS_FMA;
      end
      default: ;
    endcase

    case (r.alu_class)
      CLS_ADDR: r.alu_operation = OP_ADD;
      CLS_IMM: begin
        if (opc == OPC_BRANCH) begin
          case (f3) inside
            [3'd0:3'd1]: r.alu_operation = OP_SUB;
            [3'd4:3'd5]: r.alu_operation = OP_SLT;
            [3'd6:3'd7]: r.alu_operation = OP_SLTU;
            default:     r.alu_operation = OP_NONE;
          endcase
        end else begin
          case (f3)
            3'd0:    r.alu_operation = OP_ADD;
            3'd1:    r.alu_operation = OP_SLL;
            3'd2:    r.alu_operation = OP_SLT;
            3'd3:    r.alu_operation = OP_SLTU;
            3'd4:    r.alu_operation = OP_XOR;
            3'd5:    r.alu_operation = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
            3'd6:    r.alu_operation = OP_OR;
            default: r.alu_operation = OP_AND;
          endcase
        end
      end
      CLS_REG: begin
        if (opc == OPC_OPW || opc == OPC_OP_IMMW) r.alu_operation = wide_op(opc, f3, f7);
        else r.alu_operation = rtype_op(f3, f7);
      end
      CLS_FP: r.alu_operation = fp_op(f3, f5, f7);
      default: begin
        // opcode bits 3..2 pick madd, msub, nmsub, nmadd; any nonzero fmt is double
        r.alu_operation = OP_FMADD_S + {4'd0, opc[3:2], 1'b0} + {6'd0, |w[26:25]};
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/rv64_instruction_decoder_unit.sv =====
// channel   dir  tdata                              notes
// s_axis    in   [31:0] instruction_word            one instruction per beat
// m_axis    out  [15:0] flags, alu_class, alu_op    one decoded result per beat
//
// an accepted input beat is captured in the input register, then decoded into the result register
// throughput is one beat per cycle while m_axis is ready: input register, decode logic, result register
// the decode between the two registers is a single opcode/funct table lookup
// reset (rst_ni low, asynchronous) empties both stages; no payload is cleared
// a stall on m_axis backs up through both stages; s_axis keeps taking beats
// while either stage has room
`timescale 1ns / 1ps

module rv64_instruction_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] instruction_word
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] write_register, [1] use_immediate, [2] load_to_register, [3] read_memory,
  // [4] write_memory, [5] is_branch, [8:6] alu_class, [15:9] alu_operation
  output logic [15:0] m_axis_tdata_o
);
  import rv64idu_pkg::*;

  // input stage
  logic        in_vld_q;
  logic [31:0] instr_q;
  // result stage
  logic        out_vld_q;
  dec_result_t res_q;
  dec_result_t res_d;

  logic out_room;
  logic in_room;
  logic in_beat;
  logic move;

  // a stage has room when empty or when its content leaves this cycle
  assign out_room = !out_vld_q || m_axis_tready_i;
  assign move     = in_vld_q && out_room;
  assign in_room  = !in_vld_q || out_room;
  assign in_beat  = s_axis_tvalid_i && in_room;

  assign s_axis_tready_o = in_room;

  // decode sits between the two registers
  assign res_d = decode(instr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_room) in_vld_q <= s_axis_tvalid_i;
      if (out_room) out_vld_q <= in_vld_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_beat) instr_q <= s_axis_tdata_i;
    if (move) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {res_q.alu_operation,
                            res_q.alu_class,
                            res_q.is_branch,
                            res_q.write_memory,
                            res_q.read_memory,
                            res_q.load_to_register,
                            res_q.use_immediate,
                            res_q.write_register};

  `include "rv64_instruction_decoder_unit_assert.svh"

  // a decoded instruction always reaches the result stage on the next edge
  `RIDU_NEXT(a_stage_move, move, out_vld_q, "decoded beat lost between stages")
  // address-add class always means a plain add
  `RIDU_IMPLY(a_addr_is_add, out_vld_q && (res_q.alu_class == CLS_ADDR),
              res_q.alu_operation == OP_ADD, "address class without add")
  // branches never write a register or touch memory
  `RIDU_IMPLY(a_branch_clean, out_vld_q && res_q.is_branch,
              !res_q.write_register && !res_q.read_memory && !res_q.write_memory
              && (res_q.alu_class == CLS_IMM), "branch with side effects")
  // loads go to the register file via the immediate address
  `RIDU_IMPLY(a_load_flags, out_vld_q && res_q.read_memory,
              res_q.load_to_register && res_q.write_register && res_q.use_immediate,
              "inconsistent load flags")

endmodule

// ===== test/tb_rv64_instruction_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_rv64_instruction_decoder_unit;
  import rv64idu_pkg::*;

  localparam int unsigned RandomItems = 1750;
  localparam int unsigned MidDrainAt  = 800;
  // settle time after the final drain, covering the input register and the result register
  localparam int unsigned SettleCycles = 8;

  // opcodes that the decoder knows; most random beats use one of these
  localparam logic [6:0] KnownOpcodes [18] = '{
    OPC_LOAD, OPC_LOAD_FP, OPC_OP_IMM, OPC_AUIPC, OPC_OP_IMMW, OPC_STORE,
    OPC_STOREFP, OPC_OP, OPC_LUI, OPC_OPW, OPC_MADD, OPC_MSUB, OPC_NMSUB,
    OPC_NMADD, OPC_OP_FP, OPC_BRANCH, OPC_JALR, OPC_JAL
  };

  // fp funct7 groups, precision bit appended at random
  localparam logic [5:0] FpGroups [12] = '{
    FG_ADD, FG_SUB, FG_MUL, FG_DIV, FG_SGNJ, FG_MINX, FG_SQRT, FG_CMP,
    FG_CVTFI, FG_CVTIF, FG_MVX, FG_MVF
  };

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_PATTERN
  } ready_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] instruction_word
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // [0] write_register, [1] use_immediate, [2] load_to_register, [3] read_memory,
  // [4] write_memory, [5] is_branch, [8:6] alu_class, [15:9] alu_operation
  logic [15:0] m_axis_tdata_o;

  rv64_instruction_decoder_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // decode predictor and queue of pending decoded controls
  class decode_scoreboard;
    typedef struct {
      logic [31:0] word;
      dec_result_t fields;
    } pending_decode_t;

    pending_decode_t pending_decodes[$];
    int unsigned     errors;
    int unsigned     reported;

    function logic [6:0] register_op(logic [2:0] f3, logic [6:0] f7);
      logic m;
      logic alt;
      m   = (f7 == F7_MEXT);
      alt = (f7 == F7_ALT);
      case (f3)
        3'd0:    return m ? OP_MUL : (alt ? OP_SUB : OP_ADD);
        3'd1:    return m ? OP_MULH : OP_SLL;
        3'd2:    return m ? OP_MULHSU : OP_SLT;
        3'd3:    return m ? OP_MULHU : OP_SLTU;
        3'd4:    return m ? OP_DIV : OP_XOR;
        3'd5:    return m ? OP_DIVU : (alt ? OP_SRA : OP_SRL);
        3'd6:    return m ? OP_REM : OP_OR;
        default: return m ? OP_REMU : OP_AND;
      endcase
    endfunction

    function dec_result_t expected_controls(logic [31:0] word);
      dec_result_t r;
      logic [6:0]  opc;
      logic [6:0]  f7;
      logic [6:0]  f3x;
      logic [6:0]  f5x;
      logic [6:0]  dbl;
      logic [2:0]  f3;
      logic [4:0]  f5;
      logic        m;
      opc = word[6:0];
      f3  = word[14:12];
      f5  = word[24:20];
      f7  = word[31:25];
      f3x = {4'd0, f3};
      f5x = {2'd0, f5};
      dbl = {6'd0, f7[0]};
      m   = (f7 == F7_MEXT);
      r   = '0;
      r.alu_class = CLS_ADDR;

      // main decode on the major opcode alone
      case (opc)
        OPC_OP, OPC_OPW: begin
          r.write_register = 1'b1;
          r.alu_class      = CLS_REG;
        end
        OPC_OP_IMM: begin
          r.write_register = 1'b1;
          r.use_immediate  = 1'b1;
          r.alu_class      = CLS_IMM;
        end
        OPC_LOAD, OPC_LOAD_FP: begin
          r.write_register   = 1'b1;
          r.use_immediate    = 1'b1;
          r.load_to_register = 1'b1;
          r.read_memory      = 1'b1;
        end
        OPC_STORE, OPC_STOREFP: begin
          r.use_immediate = 1'b1;
          r.write_memory  = 1'b1;
        end
        OPC_BRANCH: begin
          r.is_branch = 1'b1;
          r.alu_class = CLS_IMM;
        end
        OPC_LUI, OPC_JALR: begin
          r.write_register = 1'b1;
          r.use_immediate  = 1'b1;
        end
        OPC_AUIPC, OPC_JAL: r.write_register = 1'b1;
        OPC_OP_IMMW: begin
          r.write_register = 1'b1;
          r.use_immediate  = 1'b1;
          r.alu_class      = CLS_REG;
        end
        OPC_OP_FP: begin
          r.write_register = 1'b1;
          r.alu_class      = CLS_FP;
        end
        OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
          r.write_register = 1'b1;
          r.alu_class      = CLS_FMA;
        end
        default: ;
      endcase

      // operation refinement per class
      r.alu_operation = OP_NONE;
      case (r.alu_class)
        CLS_ADDR: r.alu_operation = OP_ADD;
        CLS_IMM: begin
          if (opc == OPC_BRANCH) begin
            if (f3 <= 3'd1) r.alu_operation = OP_SUB;
            else if (f3 == 3'd4 || f3 == 3'd5) r.alu_operation = OP_SLT;
            else if (f3 >= 3'd6) r.alu_operation = OP_SLTU;
          end else begin
            case (f3)
              3'd0:    r.alu_operation = OP_ADD;
              3'd1:    r.alu_operation = OP_SLL;
              3'd2:    r.alu_operation = OP_SLT;
              3'd3:    r.alu_operation = OP_SLTU;
              3'd4:    r.alu_operation = OP_XOR;
              3'd5:    r.alu_operation = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
              3'd6:    r.alu_operation = OP_OR;
              default: r.alu_operation = OP_AND;
            endcase
          end
        end
        CLS_REG: begin
          r.alu_operation = register_op(f3, f7);
          // word forms override; unlisted ones fall back to the 64-bit op
          if (opc != OPC_OP) begin
            case (f3)
              3'd0: begin
                if (opc == OPC_OP_IMMW) r.alu_operation = OP_ADDW;
                else if (m) r.alu_operation = OP_MULW;
                else if (f7 == F7_ALT) r.alu_operation = OP_SUBW;
                else r.alu_operation = OP_ADDW;
              end
              3'd1: r.alu_operation = OP_SLLW;
              3'd4: if (m) r.alu_operation = OP_DIVW;
              3'd5: begin
                if (m) r.alu_operation = OP_DIVUW;
                else r.alu_operation = (f7 == F7_ALT) ? OP_SRAW : OP_SRLW;
              end
              3'd6: if (m) r.alu_operation = OP_REMW;
              3'd7: if (m) r.alu_operation = OP_REMUW;
              default: ;
            endcase
          end
        end
        CLS_FP: begin
          case (f7[6:1])
            FG_ADD:  r.alu_operation = OP_FADD_S + dbl;
            FG_SUB:  r.alu_operation = OP_FSUB_S + dbl;
            FG_MUL:  r.alu_operation = OP_FMUL_S + dbl;
            FG_DIV:  r.alu_operation = OP_FDIV_S + dbl;
            FG_SQRT: if (f5 == 5'd0) r.alu_operation = OP_FSQRT_S + dbl;
            FG_SGNJ: if (f3 <= 3'd2) r.alu_operation = OP_FSGNJ_S + 7'd3 * dbl + f3x;
            FG_MINX: if (f3 <= 3'd1) r.alu_operation = OP_FMIN_S + 7'd2 * dbl + f3x;
            // compare codes run eq, lt, le while funct3 runs le, lt, eq
            FG_CMP: begin
              if (f3 <= 3'd2) r.alu_operation = OP_FEQ_S + 7'd3 * dbl + (7'd2 - f3x);
            end
            FG_CVTFI: begin
              if (f5 <= 5'd3) r.alu_operation = (f7[0] ? OP_FCVT_W_D : OP_FCVT_W_S) + f5x;
            end
            FG_CVTIF: begin
              if (f5 <= 5'd3) r.alu_operation = (f7[0] ? OP_FCVT_D_W : OP_FCVT_S_W) + f5x;
            end
            FG_MVX: begin
              if (f3 == 3'd1) r.alu_operation = OP_FCLASS_S + 7'd2 * dbl;
              else if (f3 == 3'd0) r.alu_operation = OP_FMV_X_W + 7'd2 * dbl;
            end
            FG_MVF:  r.alu_operation = f7[0] ? OP_FMV_D_X : OP_FMV_W_X;
            default: ;
          endcase
        end
        default: begin
          // opcode bits 3..2 pick the fma flavor, any nonzero format is double
          r.alu_operation = OP_FMADD_S + {4'd0, opc[3:2], 1'b0} + {6'd0, |word[26:25]};
        end
      endcase
      return r;
    endfunction

    function void note_instruction(logic [31:0] word);
      pending_decode_t p;
      p.word   = word;
      p.fields = expected_controls(word);
      pending_decodes.push_back(p);
    endfunction

    function void check_result(logic [15:0] beat);
      dec_result_t     got;
      pending_decode_t p;
      got.write_register   = beat[0];
      got.use_immediate    = beat[1];
      got.load_to_register = beat[2];
      got.read_memory      = beat[3];
      got.write_memory     = beat[4];
      got.is_branch        = beat[5];
      got.alu_class        = alu_class_e'(beat[8:6]);
      got.alu_operation    = beat[15:9];
      if (pending_decodes.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat %04h with no instruction pending", beat);
        end
        return;
      end
      p = pending_decodes.pop_front();
      if (got.write_register !== p.fields.write_register ||
          got.use_immediate !== p.fields.use_immediate ||
          got.load_to_register !== p.fields.load_to_register ||
          got.read_memory !== p.fields.read_memory ||
          got.write_memory !== p.fields.write_memory ||
          got.is_branch !== p.fields.is_branch ||
          got.alu_class !== p.fields.alu_class ||
          got.alu_operation !== p.fields.alu_operation) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("mismatch on %08h: expected wr%b imm%b ld%b rd%b st%b br%b cls%0d op%0d",
                   p.word, p.fields.write_register, p.fields.use_immediate,
                   p.fields.load_to_register, p.fields.read_memory, p.fields.write_memory,
                   p.fields.is_branch, p.fields.alu_class, p.fields.alu_operation);
          $display("  got wr%b imm%b ld%b rd%b st%b br%b cls%0d op%0d",
                   got.write_register, got.use_immediate, got.load_to_register,
                   got.read_memory, got.write_memory, got.is_branch, got.alu_class,
                   got.alu_operation);
        end
      end
    endfunction
  endclass

  decode_scoreboard board;

  // instruction with the given decode fields; register numbers are random
  function automatic logic [31:0] pack_instruction(logic [6:0] f7, logic [4:0] f5,
                                                   logic [2:0] f3, logic [6:0] opc);
    return {f7, f5, 5'($urandom), f3, 5'($urandom), opc};
  endfunction

  // mostly well-formed instructions with random fields, some pure noise
  function automatic logic [31:0] random_instruction();
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [4:0]  f5;
    int unsigned pick;
    if ($urandom_range(0, 99) < 12) return $urandom;
    opc  = KnownOpcodes[$urandom_range(0, 17)];
    // small funct5 values reach the listed conversions and the sqrt case
    f5   = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4));
    pick = $urandom_range(0, 4);
    if (opc == OPC_OP_FP && pick < 4) begin
      f7 = {FpGroups[$urandom_range(0, 11)], 1'($urandom)};
    end else begin
      case (pick)
        0:       f7 = F7_ALT;
        1:       f7 = F7_MEXT;
        2:       f7 = '0;
        3:       f7 = F7_ALT | F7_MEXT;
        default: f7 = 7'($urandom);
      endcase
    end
    return pack_instruction(f7, f5, 3'($urandom), opc);
  endfunction

  // hold one beat on s_axis until it is taken
  task automatic send_instruction(input logic [31:0] word);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_instruction(word);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending until every decoded result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_decodes.size() != 0);
  endtask

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: check every taken beat, stall in changing patterns
  initial begin : result_sink
    ready_mode_e ready_mode;
    int unsigned hold;
    logic [7:0]  pattern;
    ready_mode      = READY_ALWAYS;
    hold            = 0;
    pattern         = 8'hA5;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
      if (hold == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        hold       = $urandom_range(30, 300);
        pattern    = 8'($urandom);
      end else begin
        hold--;
      end
      case (ready_mode)
        READY_ALWAYS: m_axis_tready_i <= 1'b1;
        READY_HALF:   m_axis_tready_i <= 1'($urandom);
        READY_SPARSE: m_axis_tready_i <= ($urandom_range(0, 4) == 0);
        default: begin
          m_axis_tready_i <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
      endcase
    end
  end

  initial begin : stimulus
    logic [31:0] directed_words[$];
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          mid_drained;
    board           = new;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero and all-one words both hit unknown opcodes
    directed_words.push_back(32'h0000_0000);
    directed_words.push_back(32'hFFFF_FFFF);
    // jal only writes a register
    directed_words.push_back(pack_instruction('0, '0, 3'd0, OPC_JAL));
    // branch funct3 with no compare operation
    directed_words.push_back(pack_instruction('0, '0, 3'd2, OPC_BRANCH));
    directed_words.push_back(pack_instruction('1, '1, 3'd3, OPC_BRANCH));
    // shift right immediate: arithmetic only on the exact alt funct7
    directed_words.push_back(pack_instruction(F7_ALT, '0, 3'd5, OPC_OP_IMM));
    directed_words.push_back(pack_instruction(F7_ALT | F7_MEXT, '0, 3'd5, OPC_OP_IMM));
    // word forms that fall back to the 64-bit operation
    directed_words.push_back(pack_instruction('0, '0, 3'd4, OPC_OPW));
    directed_words.push_back(pack_instruction(F7_ALT, '0, 3'd6, OPC_OPW));
    directed_words.push_back(pack_instruction('0, '0, 3'd7, OPC_OPW));
    directed_words.push_back(pack_instruction(F7_MEXT, '0, 3'd2, OPC_OPW));
    directed_words.push_back(pack_instruction('0, '0, 3'd3, OPC_OPW));
    // addiw ignores the m funct7
    directed_words.push_back(pack_instruction(F7_MEXT, '0, 3'd0, OPC_OP_IMMW));
    // remu on the 64-bit register form
    directed_words.push_back(pack_instruction(F7_MEXT, '0, 3'd7, OPC_OP));
    directed_words.push_back(pack_instruction(F7_ALT, '0, 3'd0, OPC_OP));
    // fp: unlisted funct7, sqrt with nonzero funct5, move from integer
    directed_words.push_back(pack_instruction('1, '1, 3'd7, OPC_OP_FP));
    directed_words.push_back(pack_instruction({FG_SQRT, 1'b0}, 5'd1, 3'd0, OPC_OP_FP));
    directed_words.push_back(pack_instruction({FG_MVF, 1'b1}, '0, 3'd0, OPC_OP_FP));
    // fma single and double formats
    directed_words.push_back(pack_instruction('0, '0, 3'd0, OPC_MADD));
    directed_words.push_back(pack_instruction(7'b1111111, '1, 3'd7, OPC_NMADD));
    directed_words.push_back(pack_instruction('0, '0, 3'd3, OPC_LOAD));
    directed_words.push_back(pack_instruction('0, '0, 3'd3, OPC_STOREFP));
    directed_words.push_back(pack_instruction('1, '1, 3'd0, OPC_LUI));
    directed_words.push_back(pack_instruction('0, '0, 3'd0, OPC_AUIPC));
    directed_words.push_back(pack_instruction('0, '0, 3'd0, OPC_JALR));
    foreach (directed_words[i]) send_instruction(directed_words[i]);
    drain_results();

    // random part in bursts, with one full drain partway through
    sent        = 0;
    mid_drained = 1'b0;
    while (sent < RandomItems) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
      repeat (burst) begin
        send_instruction(random_instruction());
        sent++;
      end
      if (!mid_drained && sent >= MidDrainAt) begin
        drain_results();
        mid_drained = 1'b1;
      end else begin
        gap = $urandom_range(0, 6);
        if (gap != 0) idle_sender(gap);
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    board.errors += board.pending_decodes.size();
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== rv64_instruction_decoder_unit.f =====
+incdir+hdl
hdl/rv64idu_pkg.sv
hdl/rv64_instruction_decoder_unit.sv
test/tb_rv64_instruction_decoder_unit.sv
